[src/olt_pkg.sv]
package olt_pkg;

  localparam int OP_W       = 2;
  localparam int VALUE_W    = 16;
  localparam int POS_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 5;

  localparam int DEPTH_DEF      = 16;
  localparam int VALUE_BITS_DEF = 16;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_READ   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic append;
    logic insert;
    logic delete;
  } cell_cmd_t;

endpackage

[src/olt_cell.sv]
module olt_cell #(
  parameter int IDX        = 0,
  parameter int VALUE_BITS = 16,
  parameter int CNT_W      = 5
) (
  input  logic                     clk_i,
  input  olt_pkg::cell_cmd_t       cmd_i,
  input  logic [VALUE_BITS-1:0]    value_i,
  input  logic [CNT_W-1:0]         count_i,
  input  logic [olt_pkg::POS_W-1:0] pos_i,
  input  logic [VALUE_BITS-1:0]    left_i,
  input  logic [VALUE_BITS-1:0]    right_i,
  input  logic                     lt_i,
  output logic                     lt_o,
  input  logic                     hit_i,
  output logic                     hit_o,
  input  logic [VALUE_BITS-1:0]    rd_i,
  output logic [VALUE_BITS-1:0]    rd_o,
  output logic [VALUE_BITS-1:0]    entry_o
);
  import olt_pkg::*;

  logic [VALUE_BITS-1:0] entry_q, entry_d;
  logic                  used;
  logic                  is_tail;
  logic                  my_lt;
  logic                  my_eq;
  logic                  sel;

  assign used    = count_i > CNT_W'(IDX);
  assign is_tail = count_i == CNT_W'(IDX);
  assign my_lt   = used && (entry_q < value_i);
  assign my_eq   = used && (entry_q == value_i);

  // lt chain: every entry up to here is smaller than the value
  assign lt_o  = lt_i && my_lt;
  // hit chain: a match lies at or before this cell
  assign hit_o = hit_i || my_eq;

  assign sel     = used && (32'(pos_i) == IDX);
  assign rd_o    = rd_i | (sel ? entry_q : '0);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.append && is_tail) begin
      entry_d = value_i;
    end else if (cmd_i.insert) begin
      if (lt_i && !my_lt) begin
        entry_d = value_i;
      end else if (!lt_i) begin
        entry_d = left_i;
      end
    end else if (cmd_i.delete && hit_o) begin
      entry_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

[src/ordered_list_table.sv]
// ordered list table: a bounded list of values held in a row of cells,
// one entry per cell, head in cell 0.
// command channel: an item (operation_i, value_i, position_i) is taken at a
// rising edge with start_i high and busy_o low. busy_o stays low, so a new
// item can be issued in every cycle.
// operations: append at tail, ordered insert before the first entry that is
// not smaller, delete of the first equal entry, read at a position.
// every item answers with exactly one result: done_o is high for one cycle,
// the edge after the item was taken, with read_value_o, status_o and
// entry_count_o (entries held after that item).
// throughput is one item per cycle; the compare, shift and read chains run
// through all cells in the cycle the item is taken.
// a full list refuses appends and inserts, a delete without a match and a
// read past the last entry are flagged and change nothing.
// reset clears the entry count and the result strobe; cell contents are not
// cleared and are never read before they are written.
// the receiver cannot stall: a result is shown for its one cycle only.
module ordered_list_table #(
  parameter int DEPTH      = olt_pkg::DEPTH_DEF,
  parameter int VALUE_BITS = olt_pkg::VALUE_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [olt_pkg::OP_W-1:0]     operation_i,
  input  logic [olt_pkg::VALUE_W-1:0]  value_i,
  input  logic [olt_pkg::POS_W-1:0]    position_i,
  output logic                         done_o,
  output logic [olt_pkg::VALUE_W-1:0]  read_value_o,
  output logic [olt_pkg::STATUS_W-1:0] status_o,
  output logic [olt_pkg::COUNT_W-1:0]  entry_count_o
);
  import olt_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int WIDE  = (VALUE_BITS > VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int OCW   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  logic                  accept;
  op_e                   op;
  logic [WIDE-1:0]       v_ext;
  logic [VALUE_BITS-1:0] v;
  logic                  full;
  logic                  found;
  logic                  in_range;
  cell_cmd_t             cmd;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  done_q;
  logic [VALUE_W-1:0]    rd_q, rd_d;
  status_e               st_q, st_d;

  logic [DEPTH:0]        lt_c;
  logic [DEPTH:0]        hit_c;
  logic [VALUE_BITS-1:0] rd_c [DEPTH+1];
  logic [VALUE_BITS-1:0] entry [DEPTH];
  logic [WIDE-1:0]       rd_ext;
  logic [OCW-1:0]        cnt_ext;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign op       = op_e'(operation_i);
  assign v_ext    = WIDE'(value_i);
  assign v        = v_ext[VALUE_BITS-1:0];
  assign full     = count_q == CNT_W'(DEPTH);
  assign found    = hit_c[DEPTH];
  assign in_range = 32'(position_i) < 32'(count_q);

  assign lt_c[0]  = 1'b1;
  assign hit_c[0] = 1'b0;
  assign rd_c[0]  = '0;
  assign rd_ext   = WIDE'(rd_c[DEPTH]);

  always_comb begin
    cmd.append = accept && (op == OP_APPEND) && !full;
    cmd.insert = accept && (op == OP_INSERT) && !full;
    cmd.delete = accept && (op == OP_DELETE) && found;
  end

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [VALUE_BITS-1:0] left, right;
    if (k == 0) begin : g_head
      assign left = v;
    end else begin : g_mid_l
      assign left = entry[k-1];
    end
    if (k == DEPTH - 1) begin : g_last
      assign right = entry[k];
    end else begin : g_mid_r
      assign right = entry[k+1];
    end

    olt_cell #(
      .IDX        (k),
      .VALUE_BITS (VALUE_BITS),
      .CNT_W      (CNT_W)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .value_i (v),
      .count_i (count_q),
      .pos_i   (position_i),
      .left_i  (left),
      .right_i (right),
      .lt_i    (lt_c[k]),
      .lt_o    (lt_c[k+1]),
      .hit_i   (hit_c[k]),
      .hit_o   (hit_c[k+1]),
      .rd_i    (rd_c[k]),
      .rd_o    (rd_c[k+1]),
      .entry_o (entry[k])
    );
  end

  always_comb begin
    count_d = count_q;
    rd_d    = '0;
    st_d    = ST_OK;
    unique case (op)
      OP_APPEND, OP_INSERT: begin
        if (full) begin
          st_d = ST_FULL;
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      OP_DELETE: begin
        if (!found) begin
          st_d = ST_NOT_FOUND;
        end else begin
          count_d = count_q - CNT_W'(1);
        end
      end
      OP_READ: begin
        if (!in_range) begin
          st_d = ST_RANGE;
        end else begin
          rd_d = rd_ext[VALUE_W-1:0];
        end
      end
      default: begin
        st_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= accept;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= rd_d;
      st_q <= st_d;
    end
  end

  assign cnt_ext       = OCW'(count_q);
  assign done_o        = done_q;
  assign read_value_o  = rd_q;
  assign status_o      = st_q;
  assign entry_count_o = cnt_ext[COUNT_W-1:0];

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("item taken without a result in the next cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without an item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_full_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (st_q == ST_FULL)) |-> (count_q == CNT_W'(DEPTH)))
    else $error("full status with room left");

  a_miss_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (st_q == ST_NOT_FOUND)) |-> $stable(count_q))
    else $error("failed delete changed the count");

endmodule
